// ===== rtl/fafp_pkg.sv =====
// ----------------------------------------------------------------------------
// fafp_pkg: shared types, constants and rounding helpers
// Fixed-point formats, CORDIC arctangent table and Q30 multiply helpers for
// the five-axis forward position pipeline.
// ----------------------------------------------------------------------------
package fafp_pkg;

	localparam int CORDIC_STAGES = 24;

	localparam int AW = 36;	// residual angle, Q30
	localparam int CW = 34;	// sine, cosine and trig products, Q30
	localparam int PW = 36;	// position times coefficient, Q16.16
	localparam int SW = 40;	// unsaturated tool coordinate

	typedef logic signed [31:0] q16_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [CW-1:0] trig_t;
	typedef logic signed [PW-1:0] prodp_t;
	typedef logic signed [SW-1:0] sum_t;

	typedef struct packed {
		q16_t fx;
		q16_t fy;
		q16_t fz;
		q16_t px;
		q16_t py;
		q16_t pz;
	} pose_t;

	// angle lanes
	localparam int IR = 0;
	localparam int IT = 1;
	localparam int IF = 2;
	localparam int IP = 3;
	localparam int NANG = 4;

	localparam ang_t Q30_PI      = AW'(64'sd3373259426);
	localparam ang_t Q30_TWO_PI  = AW'(64'sd6746518852);
	localparam ang_t Q30_HALF_PI = AW'(64'sd1686629713);
	localparam trig_t Q30_GAIN   = CW'(64'sd652032874);

	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686, 30'd33543515, 30'd16775850, 30'd8388437,
		30'd4194282, 30'd2097149, 30'd1048575, 30'd524287,
		30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127,
		30'd63, 30'd31, 30'd15, 30'd8,
		30'd4, 30'd2, 30'd1, 30'd0
	};

	// Q30 x Q30, round half up, floor shift
	function automatic trig_t mq_trig(input trig_t a, input trig_t b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		p = p + (2*CW)'(64'sd536870912);
		return CW'(p >>> 30);
	endfunction

	// Q16.16 x Q30 -> Q16.16, same rounding
	function automatic prodp_t mq_pos(input q16_t a, input trig_t b);
		logic signed [32+CW-1:0] p;
		p = a * b;
		p = p + (32+CW)'(64'sd536870912);
		return PW'(p >>> 30);
	endfunction

	function automatic q16_t sat32(input sum_t v);
		if (v > sum_t'(64'sd2147483647)) begin
			return q16_t'(32'sh7fffffff);
		end else if (v < sum_t'(-64'sd2147483648)) begin
			return q16_t'(32'sh80000000);
		end
		return q16_t'(v);
	endfunction

endpackage

// ===== rtl/five_axis_forward_position.sv =====
// ----------------------------------------------------------------------------
// five_axis_forward_position: tool-point forward kinematics
// Folds four joint angles, runs a CORDIC per angle, evaluates the x, y, z
// trigonometric polynomials and saturates the tool point to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: in_valid / in_stall carry one pose per beat (frame point,
//  plate point, four Q4.28 angles). Output channel: out_valid / out_stall
//  carry tool_x, tool_y, tool_z (Q16.16, saturated).
//  Config channel: cfg_valid / cfg_ready write tool_z_offset; cfg_ready is
//  always high. Write it only while no pose is in flight.
//  Stages from input beat to output beat: two fold stages, one register
//  per CORDIC iteration, sign fix, three trig multiply levels with an add
//  stage after the second and after the third, one position multiply level,
//  one sum stage and the output register. Throughput: one pose per cycle
//  unless out_stall freezes the pipeline; every stage holds one pose.
//  When out_stall is high with a beat waiting, the whole pipeline freezes
//  and in_stall goes high the same cycle; nothing is dropped or repeated.
//  Reset clears all valid bits and sets tool_z_offset to zero.
// ----------------------------------------------------------------------------
module five_axis_forward_position (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fafp_pkg::q16_t       frame_x,
	input  fafp_pkg::q16_t       frame_y,
	input  fafp_pkg::q16_t       frame_z,
	input  fafp_pkg::q16_t       plate_x,
	input  fafp_pkg::q16_t       plate_y,
	input  fafp_pkg::q16_t       plate_z,
	input  fafp_pkg::q16_t       angle_rho,
	input  fafp_pkg::q16_t       angle_theta,
	input  fafp_pkg::q16_t       angle_phi,
	input  fafp_pkg::q16_t       angle_psi,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  fafp_pkg::q16_t       tool_z_offset,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fafp_pkg::q16_t       tool_x,
	output fafp_pkg::q16_t       tool_y,
	output fafp_pkg::q16_t       tool_z
);

	localparam int N = fafp_pkg::CORDIC_STAGES;

	logic adv;
	fafp_pkg::q16_t zo_q;

	// fold stage 1 and CORDIC chain
	logic                  vld_f1;
	fafp_pkg::ang_t        ang_f1 [fafp_pkg::NANG];
	fafp_pkg::pose_t       pose_f1;
	logic [N:0]            vld_c;
	fafp_pkg::ang_t        ang_c  [N+1][fafp_pkg::NANG];
	fafp_pkg::trig_t       cx_c   [N+1][fafp_pkg::NANG];
	fafp_pkg::trig_t       cy_c   [N+1][fafp_pkg::NANG];
	logic                  flip_c [N+1][fafp_pkg::NANG];
	fafp_pkg::pose_t       pose_c [N+1];

	// post-rotator stages, numbered from 1 again
	logic [8:1]            vld_p;
	fafp_pkg::pose_t       pose_p [1:7];
	fafp_pkg::trig_t       sin_p  [1:6][fafp_pkg::NANG];
	fafp_pkg::trig_t       cos_p  [1:6][fafp_pkg::NANG];

	fafp_pkg::trig_t cr_st_s2, cf_ct_s2, cr_ct_s2, cf_sr_s2, sr_st_s2, cf_cr_s2, cs_ct_s2;
	fafp_pkg::trig_t ct_sf_s2, cf_cs_s2, sf_ss_s2, cf_ss_s2, cs_sf_s2, cr_sf_s2, ct_sr_s2;

	fafp_pkg::trig_t cf_ct_sr_s3, cf_sr_st_s3, cf_cr_ct_s3, cs_ct_sf_s3, ct_sf_ss_s3;
	fafp_pkg::trig_t sf_ss_sr_s3, cs_sf_sr_s3, cf_cr_st_s3, cs_sf_st_s3, sf_ss_st_s3;
	fafp_pkg::trig_t cr_st_s3, cr_ct_s3, sr_st_s3, cf_cs_s3, cf_ss_s3, cr_sf_s3, ct_sr_s3;

	fafp_pkg::trig_t e_s4, g_s4, kx1_s4, ky1_s4, ky2_s4, ky3_s4, kz1_s4;
	fafp_pkg::trig_t cs_ct_sf_s4, ct_sf_ss_s4, cs_sf_st_s4, sf_ss_st_s4;

	fafp_pkg::trig_t ss_e_s5, cs_e_s5, ss_g_s5, cs_g_s5;
	fafp_pkg::trig_t kx1_s5, ky1_s5, ky2_s5, ky3_s5, kz1_s5;
	fafp_pkg::trig_t cs_ct_sf_s5, ct_sf_ss_s5, cs_sf_st_s5, sf_ss_st_s5;

	fafp_pkg::trig_t kx1_s6, kx2_s6, kx3_s6, ky1_s6, ky2_s6, ky3_s6, kz1_s6, kz2_s6, kz3_s6;

	fafp_pkg::prodp_t qx1_s7, qx2_s7, qx3_s7, qxo_s7, qy1_s7, qy2_s7, qy3_s7;
	fafp_pkg::prodp_t qz1_s7, qz2_s7, qz3_s7, qzo_s7;

	fafp_pkg::sum_t tx_s8, ty_s8, tz_s8;

	logic            out_valid_q;
	fafp_pkg::q16_t  tool_x_q, tool_y_q, tool_z_q;

	fafp_pkg::q16_t  ang_in [fafp_pkg::NANG];

	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign tool_x    = tool_x_q;
	assign tool_y    = tool_y_q;
	assign tool_z    = tool_z_q;

	assign ang_in[fafp_pkg::IR] = angle_rho;
	assign ang_in[fafp_pkg::IT] = angle_theta;
	assign ang_in[fafp_pkg::IF] = angle_phi;
	assign ang_in[fafp_pkg::IP] = angle_psi;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zo_q        <= '0;
			vld_f1      <= 1'b0;
			vld_c       <= '0;
			vld_p       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				zo_q <= tool_z_offset;
			end
			if (adv) begin
				vld_f1      <= in_valid;
				vld_c       <= {vld_c[N-1:0], vld_f1};
				vld_p       <= {vld_p[7:1], vld_c[N]};
				out_valid_q <= vld_p[8];
			end
		end
	end

	// fold by two pi, then by pi with a sign flip
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < fafp_pkg::NANG; j++) begin
				fafp_pkg::ang_t a;
				a = {{(fafp_pkg::AW-34){ang_in[j][31]}}, ang_in[j], 2'b00};
				if (a > fafp_pkg::Q30_PI) begin
					ang_f1[j] <= a - fafp_pkg::Q30_TWO_PI;
				end else if (a < -fafp_pkg::Q30_PI) begin
					ang_f1[j] <= a + fafp_pkg::Q30_TWO_PI;
				end else begin
					ang_f1[j] <= a;
				end
			end
			pose_f1 <= '{fx: frame_x, fy: frame_y, fz: frame_z,
				px: plate_x, py: plate_y, pz: plate_z};

			for (int j = 0; j < fafp_pkg::NANG; j++) begin
				cx_c[0][j] <= fafp_pkg::Q30_GAIN;
				cy_c[0][j] <= '0;
				if (ang_f1[j] > fafp_pkg::Q30_HALF_PI) begin
					ang_c[0][j]  <= ang_f1[j] - fafp_pkg::Q30_PI;
					flip_c[0][j] <= 1'b1;
				end else if (ang_f1[j] < -fafp_pkg::Q30_HALF_PI) begin
					ang_c[0][j]  <= ang_f1[j] + fafp_pkg::Q30_PI;
					flip_c[0][j] <= 1'b1;
				end else begin
					ang_c[0][j]  <= ang_f1[j];
					flip_c[0][j] <= 1'b0;
				end
			end
			pose_c[0] <= pose_f1;
		end
	end

	// one CORDIC iteration per register stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < fafp_pkg::NANG; j++) begin
					if (!ang_c[i][j][fafp_pkg::AW-1]) begin
						cx_c[i+1][j]  <= cx_c[i][j] - (cy_c[i][j] >>> i);
						cy_c[i+1][j]  <= cy_c[i][j] + (cx_c[i][j] >>> i);
						ang_c[i+1][j] <= ang_c[i][j] - fafp_pkg::ang_t'(fafp_pkg::ATAN_TAB[i]);
					end else begin
						cx_c[i+1][j]  <= cx_c[i][j] + (cy_c[i][j] >>> i);
						cy_c[i+1][j]  <= cy_c[i][j] - (cx_c[i][j] >>> i);
						ang_c[i+1][j] <= ang_c[i][j] + fafp_pkg::ang_t'(fafp_pkg::ATAN_TAB[i]);
					end
					flip_c[i+1][j] <= flip_c[i][j];
				end
				pose_c[i+1] <= pose_c[i];
			end
		end
	end

	// polynomial datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: undo the pi fold
			for (int j = 0; j < fafp_pkg::NANG; j++) begin
				sin_p[1][j] <= flip_c[N][j] ? -cy_c[N][j] : cy_c[N][j];
				cos_p[1][j] <= flip_c[N][j] ? -cx_c[N][j] : cx_c[N][j];
			end
			pose_p[1] <= pose_c[N];
			for (int k = 2; k <= 6; k++) begin
				sin_p[k] <= sin_p[k-1];
				cos_p[k] <= cos_p[k-1];
			end
			for (int k = 2; k <= 7; k++) begin
				pose_p[k] <= pose_p[k-1];
			end

			// s2: first trig products
			cr_st_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IR], sin_p[1][fafp_pkg::IT]);
			cf_ct_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IF], cos_p[1][fafp_pkg::IT]);
			cr_ct_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IR], cos_p[1][fafp_pkg::IT]);
			cf_sr_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IF], sin_p[1][fafp_pkg::IR]);
			sr_st_s2 <= fafp_pkg::mq_trig(sin_p[1][fafp_pkg::IR], sin_p[1][fafp_pkg::IT]);
			cf_cr_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IF], cos_p[1][fafp_pkg::IR]);
			cs_ct_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IP], cos_p[1][fafp_pkg::IT]);
			ct_sf_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IT], sin_p[1][fafp_pkg::IF]);
			cf_cs_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IF], cos_p[1][fafp_pkg::IP]);
			sf_ss_s2 <= fafp_pkg::mq_trig(sin_p[1][fafp_pkg::IF], sin_p[1][fafp_pkg::IP]);
			cf_ss_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IF], sin_p[1][fafp_pkg::IP]);
			cs_sf_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IP], sin_p[1][fafp_pkg::IF]);
			cr_sf_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IR], sin_p[1][fafp_pkg::IF]);
			ct_sr_s2 <= fafp_pkg::mq_trig(cos_p[1][fafp_pkg::IT], sin_p[1][fafp_pkg::IR]);

			// s3: chained triple products, left to right
			cf_ct_sr_s3 <= fafp_pkg::mq_trig(cf_ct_s2, sin_p[2][fafp_pkg::IR]);
			cf_sr_st_s3 <= fafp_pkg::mq_trig(cf_sr_s2, sin_p[2][fafp_pkg::IT]);
			cf_cr_ct_s3 <= fafp_pkg::mq_trig(cf_cr_s2, cos_p[2][fafp_pkg::IT]);
			cs_ct_sf_s3 <= fafp_pkg::mq_trig(cs_ct_s2, sin_p[2][fafp_pkg::IF]);
			ct_sf_ss_s3 <= fafp_pkg::mq_trig(ct_sf_s2, sin_p[2][fafp_pkg::IP]);
			sf_ss_sr_s3 <= fafp_pkg::mq_trig(sf_ss_s2, sin_p[2][fafp_pkg::IR]);
			cs_sf_sr_s3 <= fafp_pkg::mq_trig(cs_sf_s2, sin_p[2][fafp_pkg::IR]);
			cf_cr_st_s3 <= fafp_pkg::mq_trig(cf_cr_s2, sin_p[2][fafp_pkg::IT]);
			cs_sf_st_s3 <= fafp_pkg::mq_trig(cs_sf_s2, sin_p[2][fafp_pkg::IT]);
			sf_ss_st_s3 <= fafp_pkg::mq_trig(sf_ss_s2, sin_p[2][fafp_pkg::IT]);
			cr_st_s3 <= cr_st_s2;
			cr_ct_s3 <= cr_ct_s2;
			sr_st_s3 <= sr_st_s2;
			cf_cs_s3 <= cf_cs_s2;
			cf_ss_s3 <= cf_ss_s2;
			cr_sf_s3 <= cr_sf_s2;
			ct_sr_s3 <= ct_sr_s2;

			// s4: first-level coefficients
			e_s4   <= cr_st_s3 + cf_ct_sr_s3;
			g_s4   <= cr_ct_s3 - cf_sr_st_s3;
			kx1_s4 <= sr_st_s3 - cf_cr_ct_s3;
			ky1_s4 <= cf_cs_s3 + sf_ss_sr_s3;
			ky2_s4 <= cf_ss_s3 - cs_sf_sr_s3;
			ky3_s4 <= cr_sf_s3;
			kz1_s4 <= ct_sr_s3 - cf_cr_st_s3;
			cs_ct_sf_s4 <= cs_ct_sf_s3;
			ct_sf_ss_s4 <= ct_sf_ss_s3;
			cs_sf_st_s4 <= cs_sf_st_s3;
			sf_ss_st_s4 <= sf_ss_st_s3;

			// s5: products with E and G
			ss_e_s5 <= fafp_pkg::mq_trig(sin_p[4][fafp_pkg::IP], e_s4);
			cs_e_s5 <= fafp_pkg::mq_trig(cos_p[4][fafp_pkg::IP], e_s4);
			ss_g_s5 <= fafp_pkg::mq_trig(sin_p[4][fafp_pkg::IP], g_s4);
			cs_g_s5 <= fafp_pkg::mq_trig(cos_p[4][fafp_pkg::IP], g_s4);
			kx1_s5 <= kx1_s4;
			ky1_s5 <= ky1_s4;
			ky2_s5 <= ky2_s4;
			ky3_s5 <= ky3_s4;
			kz1_s5 <= kz1_s4;
			cs_ct_sf_s5 <= cs_ct_sf_s4;
			ct_sf_ss_s5 <= ct_sf_ss_s4;
			cs_sf_st_s5 <= cs_sf_st_s4;
			sf_ss_st_s5 <= sf_ss_st_s4;

			// s6: remaining coefficients
			kx2_s6 <= ss_e_s5 - cs_ct_sf_s5;
			kx3_s6 <= cs_e_s5 + ct_sf_ss_s5;
			kz2_s6 <= ss_g_s5 + cs_sf_st_s5;
			kz3_s6 <= cs_g_s5 - sf_ss_st_s5;
			kx1_s6 <= kx1_s5;
			ky1_s6 <= ky1_s5;
			ky2_s6 <= ky2_s5;
			ky3_s6 <= ky3_s5;
			kz1_s6 <= kz1_s5;

			// s7: position times coefficient
			qx1_s7 <= fafp_pkg::mq_pos(pose_p[6].px, kx1_s6);
			qx2_s7 <= fafp_pkg::mq_pos(pose_p[6].py, kx2_s6);
			qx3_s7 <= fafp_pkg::mq_pos(pose_p[6].pz, kx3_s6);
			qxo_s7 <= fafp_pkg::mq_pos(zo_q, sin_p[6][fafp_pkg::IT]);
			qy1_s7 <= fafp_pkg::mq_pos(pose_p[6].py, ky1_s6);
			qy2_s7 <= fafp_pkg::mq_pos(pose_p[6].pz, ky2_s6);
			qy3_s7 <= fafp_pkg::mq_pos(pose_p[6].px, ky3_s6);
			qz1_s7 <= fafp_pkg::mq_pos(pose_p[6].px, kz1_s6);
			qzo_s7 <= fafp_pkg::mq_pos(zo_q, cos_p[6][fafp_pkg::IT]);
			qz2_s7 <= fafp_pkg::mq_pos(pose_p[6].py, kz2_s6);
			qz3_s7 <= fafp_pkg::mq_pos(pose_p[6].pz, kz3_s6);

			// s8: final sums, exact
			tx_s8 <= fafp_pkg::sum_t'(pose_p[7].fx) - fafp_pkg::sum_t'(qx1_s7)
				- fafp_pkg::sum_t'(qxo_s7) + fafp_pkg::sum_t'(qx2_s7)
				+ fafp_pkg::sum_t'(qx3_s7);
			ty_s8 <= fafp_pkg::sum_t'(pose_p[7].fy) + fafp_pkg::sum_t'(qy1_s7)
				- fafp_pkg::sum_t'(qy2_s7) + fafp_pkg::sum_t'(qy3_s7);
			tz_s8 <= fafp_pkg::sum_t'(zo_q) + fafp_pkg::sum_t'(pose_p[7].fz)
				- fafp_pkg::sum_t'(qz1_s7) - fafp_pkg::sum_t'(qzo_s7)
				+ fafp_pkg::sum_t'(qz2_s7) + fafp_pkg::sum_t'(qz3_s7);

			// output register, saturated
			tool_x_q <= fafp_pkg::sat32(tx_s8);
			tool_y_q <= fafp_pkg::sat32(ty_s8);
			tool_z_q <= fafp_pkg::sat32(tz_s8);
		end
	end

`ifndef SYNTHESIS
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[0] |-> (ang_c[0][fafp_pkg::IR] <= fafp_pkg::Q30_HALF_PI &&
			ang_c[0][fafp_pkg::IR] >= -fafp_pkg::Q30_HALF_PI))
		else $error("folded angle out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_p[8] && adv) |=> out_valid)
		else $error("finished pose did not reach the output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_c) && $stable(vld_p)))
		else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== bench/five_axis_forward_position_tb.sv =====
// ----------------------------------------------------------------------------
// five_axis_forward_position_tb: tool-point forward kinematics bench
// Drives poses through the input channel with random gaps and output stalls,
// predicts each tool point with an independent 64-bit CORDIC and polynomial
// model, and checks every result beat in order. The tool z offset is
// rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module five_axis_forward_position_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = fafp_pkg::CORDIC_STAGES;
	localparam int PIPE_DEPTH = STAGES + 11;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ANGLE_STEP [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
		15, 8, 4, 2, 1, 0
	};

	typedef struct {
		fafp_pkg::q16_t tx;
		fafp_pkg::q16_t ty;
		fafp_pkg::q16_t tz;
	} tool_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fafp_pkg::q16_t frame_x = '0, frame_y = '0, frame_z = '0;
	fafp_pkg::q16_t plate_x = '0, plate_y = '0, plate_z = '0;
	fafp_pkg::q16_t angle_rho = '0, angle_theta = '0, angle_phi = '0, angle_psi = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	fafp_pkg::q16_t tool_z_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fafp_pkg::q16_t tool_x, tool_y, tool_z;

	longint z_offset_model = 0;
	tool_pt_t expected_points[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	always #2 clk = ~clk;

	five_axis_forward_position dut (.*);

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic sin_cos(input fafp_pkg::q16_t raw, output longint s, output longint c);
		longint a, x, y, t, dx, dy;
		bit flip;
		a = longint'(raw) * 4;
		x = GAIN_Q30;
		y = 0;
		flip = 0;
		if (a > PI_Q30) a -= TWO_PI_Q30;
		else if (a < -PI_Q30) a += TWO_PI_Q30;
		if (a > HALF_PI_Q30) begin
			a -= PI_Q30;
			flip = 1;
		end else if (a < -HALF_PI_Q30) begin
			a += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (a >= 0) begin
				t = x - dx;
				y = y + dy;
				a -= ANGLE_STEP[i];
			end else begin
				t = x + dx;
				y = y - dy;
				a += ANGLE_STEP[i];
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic predict_tool_point(input fafp_pkg::q16_t f[6],
			input fafp_pkg::q16_t ang[4], output tool_pt_t p);
		longint sr, cr, st, ct, sf, cf, ss, cs, e, g, k, tx, ty, tz;
		longint fx, fy, fz, px, py, pz, zo;
		fx = f[0]; fy = f[1]; fz = f[2]; px = f[3]; py = f[4]; pz = f[5];
		zo = z_offset_model;
		sin_cos(ang[0], sr, cr);
		sin_cos(ang[1], st, ct);
		sin_cos(ang[2], sf, cf);
		sin_cos(ang[3], ss, cs);
		e = mul_q30(cr, st) + mul_q30(mul_q30(cf, ct), sr);
		g = mul_q30(cr, ct) - mul_q30(mul_q30(cf, sr), st);
		k = mul_q30(sr, st) - mul_q30(mul_q30(cf, cr), ct);
		tx = fx - mul_q30(px, k) - mul_q30(zo, st);
		k = mul_q30(ss, e) - mul_q30(mul_q30(cs, ct), sf);
		tx += mul_q30(py, k);
		k = mul_q30(cs, e) + mul_q30(mul_q30(ct, sf), ss);
		tx += mul_q30(pz, k);
		k = mul_q30(cf, cs) + mul_q30(mul_q30(sf, ss), sr);
		ty = fy + mul_q30(py, k);
		k = mul_q30(cf, ss) - mul_q30(mul_q30(cs, sf), sr);
		ty -= mul_q30(pz, k);
		ty += mul_q30(px, mul_q30(cr, sf));
		k = mul_q30(ct, sr) - mul_q30(mul_q30(cf, cr), st);
		tz = zo + fz - mul_q30(px, k) - mul_q30(zo, ct);
		k = mul_q30(ss, g) + mul_q30(mul_q30(cs, sf), st);
		tz += mul_q30(py, k);
		k = mul_q30(cs, g) - mul_q30(mul_q30(sf, ss), st);
		tz += mul_q30(pz, k);
		p.tx = fafp_pkg::q16_t'(clamp32(tx));
		p.ty = fafp_pkg::q16_t'(clamp32(ty));
		p.tz = fafp_pkg::q16_t'(clamp32(tz));
	endtask

	// one pose beat; valid stays high across back-to-back beats
	task automatic send_pose(input fafp_pkg::q16_t f[6], input fafp_pkg::q16_t ang[4]);
		tool_pt_t p;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		predict_tool_point(f, ang, p);
		in_valid <= 1'b1;
		frame_x <= f[0]; frame_y <= f[1]; frame_z <= f[2];
		plate_x <= f[3]; plate_y <= f[4]; plate_z <= f[5];
		angle_rho <= ang[0]; angle_theta <= ang[1];
		angle_phi <= ang[2]; angle_psi <= ang[3];
		do @(posedge clk); while (in_stall);
		expected_points.push_back(p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	task automatic write_z_offset(input fafp_pkg::q16_t v);
		cfg_valid <= 1'b1;
		tool_z_offset <= v;
		do @(posedge clk); while (!cfg_ready);
		z_offset_model = longint'(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic fafp_pkg::q16_t rand_word();
		case ($urandom_range(5))
			0: return fafp_pkg::q16_t'(32'h7fffffff);
			1: return fafp_pkg::q16_t'(32'h80000000);
			2: return fafp_pkg::q16_t'($urandom_range(0, 20) - 10) <<< 16;
			3: return fafp_pkg::q16_t'($signed($urandom) >>> $urandom_range(8, 20));
			default: return fafp_pkg::q16_t'($urandom);
		endcase
	endfunction

	function automatic fafp_pkg::q16_t rand_angle();
		case ($urandom_range(7))
			0: return fafp_pkg::q16_t'(32'h7fffffff);
			1: return fafp_pkg::q16_t'(32'h80000000);
			// near the fold boundaries, pi/2 and pi in Q4.28
			2: return fafp_pkg::q16_t'(32'sd421657428 + $urandom_range(0, 8) - 4);
			3: return fafp_pkg::q16_t'(-32'sd843314857 + $urandom_range(0, 8) - 4);
			4: return '0;
			default: return fafp_pkg::q16_t'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		fafp_pkg::q16_t f[6];
		fafp_pkg::q16_t ang[4];
		for (int i = 0; i < n; i++) begin
			foreach (f[j]) f[j] = rand_word();
			foreach (ang[j]) ang[j] = rand_angle();
			send_pose(f, ang);
		end
	endtask

	task automatic test_directed();
		fafp_pkg::q16_t f[6];
		fafp_pkg::q16_t ang[4];
		fafp_pkg::q16_t corner[6] = '{32'sh0, 32'sh7fffffff, 32'sh80000000,
			32'sh00010000, -32'sh00010000, 32'sh00000001};
		fafp_pkg::q16_t angs[8] = '{32'sh0, 32'sh7fffffff, 32'sh80000000,
			32'sd421657428, -32'sd421657428, 32'sd843314857,
			-32'sd843314857, 32'sd210828714};
		for (int i = 0; i < 16; i++) begin
			foreach (f[j]) f[j] = corner[(i + j) % 6];
			foreach (ang[j]) ang[j] = angs[(i * 3 + j) % 8];
			send_pose(f, ang);
		end
		// all-ones and alternating bit patterns for positions and angles
		foreach (f[j]) f[j] = 32'shffffffff;
		foreach (ang[j]) ang[j] = 32'shffffffff;
		send_pose(f, ang);
		foreach (f[j]) f[j] = 32'sh55555555;
		foreach (ang[j]) ang[j] = 32'shaaaaaaaa;
		send_pose(f, ang);
		drain();
	endtask

	task automatic test_phase(input fafp_pkg::q16_t zo, input int n, input int idle_pct,
			input int stl_pct);
		write_z_offset(zo);
		send_idle_pct = idle_pct;
		stall_pct = stl_pct;
		send_random(n);
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	// receiver stall
	always @(negedge clk)
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

	// result checker
	always @(posedge clk) begin
		tool_pt_t exp_pt;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %h %h %h", tool_x, tool_y, tool_z);
			end else begin
				exp_pt = expected_points.pop_front();
				if (tool_x !== exp_pt.tx || tool_y !== exp_pt.ty ||
						tool_z !== exp_pt.tz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h got %h %h %h",
							exp_pt.tx, exp_pt.ty, exp_pt.tz, tool_x, tool_y, tool_z);
				end
			end
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_phase(32'sh7fffffff, 300, 0, 0);
		test_phase(32'sh80000000, 250, 84, 0);
		test_phase(32'sh00050000, 250, 0, 84);
		test_phase(fafp_pkg::q16_t'($urandom), 250, 12, 12);
		test_phase(32'sh0, 300, 0, 0);
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fafp_pkg.sv
rtl/five_axis_forward_position.sv
bench/five_axis_forward_position_tb.sv
